FILE: hdl/cnes_pkg.sv
package cnes_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int CFG_W = 13;
   localparam int PIX_W = 24;
   localparam int LEVEL_FRACTION_BITS = 12;
   localparam int ROUND_SHIFT = 60 - LEVEL_FRACTION_BITS;

   localparam logic [CFG_W-1:0] RESET_WIDTH = 13'd640;
   localparam logic [CFG_W-1:0] MIN_WIDTH = 13'd3;
   localparam logic [CFG_W-1:0] MAX_WIDTH_CFG = CFG_W'(MAX_WIDTH);
   localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
   localparam logic [19:0] ARG_DEN = 20'd44167;
   localparam logic [19:0] ARG_OFFSET = 20'd88334;
   localparam logic [14:0] LEVEL_MAX = 15'd16383;
   localparam logic [14:0] LEVEL_MIN_MAG = 15'd16384;

   localparam logic [1:0] LAST_CHANNEL = 2'd2;
   localparam logic [4:0] ROOT_TOP_BIT = 5'd9;
   localparam logic [4:0] LAST_STEP = 5'd27;
   localparam logic [2:0] LAST_NEIGHBOR = 3'd7;

   typedef struct packed {
      logic       capture;
      logic       window;
      logic       sq_step;
      logic       root_step;
      logic       insert;
      logic       arg;
      logic       norm_lo;
      logic       norm_hi;
      logic       div_init;
      logic       div_step;
      logic       sq_mul;
      logic       sq_fix;
      logic       mul_lo;
      logic       mul_hi;
      logic       emit_flag;
      logic       emit_level;
      logic [2:0] nb;
      logic [4:0] idx;
   } cnes_cmd_type;

   typedef struct packed {
      logic interior;
      logic nonpos;
      logic num_lt_den;
      logic num_ge_2den;
      logic out_busy;
   } cnes_status_type;

endpackage

FILE: hdl/color_neighbor_edge_strength_unit.sv
// Sequence: a border pixel only updates the window and line buffers; an interior
// pixel computes the 8 neighbor distances, normalizes the log argument, divides,
// runs 28 squarings, then scales and outputs, or goes straight to output when the
// log argument is not positive; the result may wait for rsp_ready.
// Throughput: one transaction at a time, set by the shared distance and log sequencer.
// Reset: synchronous, active high; clears counters, window and handshakes, width 640.
module color_neighbor_edge_strength_unit
   import cnes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_channel_a,
   input  logic [7:0]          req_channel_b,
   input  logic [7:0]          req_channel_c,
   input  logic                req_start_of_frame,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_centre_row,
   output logic [11:0]         rsp_centre_column,
   output logic signed [14:0]  rsp_edge_level,
   output logic                rsp_status,
   input  logic                csr_write_enable,
   input  logic [CFG_W-1:0]    csr_write_data
);

   cnes_cmd_type cmd;
   cnes_status_type status;

   cnes_controller u_controller (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   cnes_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_channel_a(req_channel_a), .req_channel_b(req_channel_b),
      .req_channel_c(req_channel_c), .req_start_of_frame(req_start_of_frame),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_centre_row(rsp_centre_row),
      .rsp_centre_column(rsp_centre_column), .rsp_edge_level(rsp_edge_level),
      .rsp_status(rsp_status)
   );

endmodule

FILE: hdl/cnes_datapath.sv
module cnes_datapath
   import cnes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cnes_cmd_type        cmd,
   output cnes_status_type     status,
   input  logic [7:0]          req_channel_a,
   input  logic [7:0]          req_channel_b,
   input  logic [7:0]          req_channel_c,
   input  logic                req_start_of_frame,
   input  logic                csr_write_enable,
   input  logic [CFG_W-1:0]    csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_centre_row,
   output logic [11:0]         rsp_centre_column,
   output logic signed [14:0]  rsp_edge_level,
   output logic                rsp_status
);

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
   logic [PIX_W-1:0] upper_q_ff, lower_q_ff, pix_ff;
   logic [PIX_W-1:0] win_ff [9];
   logic [ADDR_W-1:0] column_count_ff, col_ff;
   logic [15:0] row_count_ff, row_ff;
   logic [CFG_W-1:0] width_ff, width_eff;
   logic [ADDR_W-1:0] col_eff;
   logic [15:0] row_eff;

   logic [17:0] acc_ff;
   logic [9:0] root_ff;
   logic [9:0] top_ff [4];
   logic [19:0] num_ff, den_ff;
   logic [20:0] rem_ff;
   logic signed [5:0] e_ff;
   logic [29:0] y_ff;
   logic [59:0] prod_ff;
   logic [27:0] frac_ff;
   logic [63:0] lmul_ff;

   logic rsp_valid_ff, rsp_status_ff;
   logic [15:0] rsp_row_ff;
   logic [11:0] rsp_col_ff;
   logic [14:0] rsp_level_ff;

   logic [PIX_W-1:0] nbr, centre;
   logic [7:0] ca, cb;
   logic signed [8:0] diff;
   logic [17:0] sq, acc_base;
   logic [9:0] root_t;
   logic [19:0] root_tt;
   logic [9:0] top_base [4];
   logic [9:0] top_in [4];
   logic [11:0] s_sum;
   logic [19:0] p_val;
   logic [20:0] rem2;
   logic [29:0] sq_t;
   logic signed [33:0] l_val, l_mag;
   logic [32:0] mag;
   logic lneg;
   logic [64:0] rsum;
   logic [64:0] r_full;
   logic [14:0] r_sat, level;

   always_comb begin
      if (width_ff < MIN_WIDTH) width_eff = MIN_WIDTH;
      else if (width_ff > MAX_WIDTH_CFG) width_eff = MAX_WIDTH_CFG;
      else width_eff = width_ff;
      col_eff = req_start_of_frame ? '0 : column_count_ff;
      row_eff = req_start_of_frame ? '0 : row_count_ff;
   end

   always_comb begin
      unique case (cmd.nb)
         3'd0: nbr = win_ff[0];
         3'd1: nbr = win_ff[1];
         3'd2: nbr = win_ff[2];
         3'd3: nbr = win_ff[3];
         3'd4: nbr = win_ff[5];
         3'd5: nbr = win_ff[6];
         3'd6: nbr = win_ff[7];
         default: nbr = win_ff[8];
      endcase
      centre = win_ff[4];
      unique case (cmd.idx[1:0])
         2'd0: begin ca = centre[7:0]; cb = nbr[7:0]; end
         2'd1: begin ca = centre[15:8]; cb = nbr[15:8]; end
         default: begin ca = centre[23:16]; cb = nbr[23:16]; end
      endcase
      diff = $signed({1'b0, ca}) - $signed({1'b0, cb});
      sq = 18'(diff) * 18'(diff);
      acc_base = (cmd.idx == '0) ? '0 : acc_ff;
      root_t = ((cmd.idx == ROOT_TOP_BIT) ? 10'd0 : root_ff) | (10'd1 << cmd.idx[3:0]);
      root_tt = 20'(root_t) * 20'(root_t);
      for (int i = 0; i < 4; i++) top_base[i] = (cmd.nb == '0) ? '0 : top_ff[i];
      for (int i = 0; i < 4; i++) begin
         if (i > 0 && root_ff > top_base[(i > 0) ? i - 1 : 0])
            top_in[i] = top_base[(i > 0) ? i - 1 : 0];
         else if (root_ff > top_base[i]) top_in[i] = root_ff;
         else top_in[i] = top_base[i];
      end
      s_sum = 12'(top_ff[0]) + 12'(top_ff[1]) + 12'(top_ff[2]) + 12'(top_ff[3]);
      p_val = 20'(s_sum) * 20'd300;
      rem2 = {rem_ff[19:0], 1'b0};
      sq_t = prod_ff[57:28];
      l_val = $signed({e_ff, frac_ff});
      lneg = e_ff[5];
      l_mag = lneg ? -l_val : l_val;
      mag = l_mag[32:0];
      rsum = {1'b0, lmul_ff} + (65'd1 << (ROUND_SHIFT - 1));
      r_full = rsum >> ROUND_SHIFT;
      r_sat = (r_full > 65'(LEVEL_MIN_MAG)) ? LEVEL_MIN_MAG : r_full[14:0];
      if (lneg) level = 15'(-r_sat);
      else level = (r_sat > LEVEL_MAX) ? LEVEL_MAX : r_sat;
   end

   assign status.interior = (row_ff >= 16'd2) && (col_ff >= ADDR_W'(2));
   assign status.nonpos = p_val <= ARG_OFFSET;
   assign status.num_lt_den = num_ff < den_ff;
   assign status.num_ge_2den = {1'b0, num_ff} >= {den_ff, 1'b0};
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         upper_q_ff <= upper_mem[col_eff];
         lower_q_ff <= lower_mem[col_eff];
      end
      if (cmd.window) begin
         upper_mem[col_ff] <= lower_q_ff;
         lower_mem[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WIDTH;
         column_count_ff <= '0;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         if (csr_write_enable) width_ff <= csr_write_data;
         if (cmd.window) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[3*i] <= win_ff[3*i+1];
               win_ff[3*i+1] <= win_ff[3*i+2];
            end
            win_ff[2] <= upper_q_ff;
            win_ff[5] <= lower_q_ff;
            win_ff[8] <= pix_ff;
            if ({1'b0, col_ff} + 13'd1 >= width_eff) begin
               column_count_ff <= '0;
               row_count_ff <= row_ff + 16'd1;
            end else begin
               column_count_ff <= col_ff + ADDR_W'(1);
               row_count_ff <= row_ff;
            end
         end
         if (cmd.emit_flag || cmd.emit_level) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= {req_channel_c, req_channel_b, req_channel_a};
         col_ff <= col_eff;
         row_ff <= row_eff;
      end
      if (cmd.sq_step) acc_ff <= acc_base + sq;
      if (cmd.root_step && {2'b00, root_tt} <= {4'b0000, acc_ff}) root_ff <= root_t;
      else if (cmd.root_step && cmd.idx == ROOT_TOP_BIT) root_ff <= '0;
      if (cmd.insert) for (int i = 0; i < 4; i++) top_ff[i] <= top_in[i];
      if (cmd.arg) begin
         num_ff <= p_val - ARG_OFFSET;
         den_ff <= ARG_DEN;
         e_ff <= '0;
      end
      if (cmd.norm_lo) begin
         num_ff <= {num_ff[18:0], 1'b0};
         e_ff <= e_ff - 6'sd1;
      end
      if (cmd.norm_hi) begin
         den_ff <= {den_ff[18:0], 1'b0};
         e_ff <= e_ff + 6'sd1;
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, num_ff - den_ff};
         y_ff <= 30'd1;
         frac_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_ff <= rem2 - {1'b0, den_ff};
            y_ff <= {y_ff[28:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            y_ff <= {y_ff[28:0], 1'b0};
         end
      end
      if (cmd.sq_mul) prod_ff <= 60'(y_ff) * 60'(y_ff);
      if (cmd.sq_fix) begin
         if (sq_t[29]) begin
            y_ff <= {1'b0, sq_t[29:1]};
            frac_ff <= {frac_ff[26:0], 1'b1};
         end else begin
            y_ff <= sq_t;
            frac_ff <= {frac_ff[26:0], 1'b0};
         end
      end
      if (cmd.mul_lo) lmul_ff <= 64'(mag[16:0]) * 64'(LOG10_2_Q32);
      if (cmd.mul_hi) lmul_ff <= lmul_ff + ((64'(mag[32:17]) * 64'(LOG10_2_Q32)) << 17);
      if (cmd.emit_flag || cmd.emit_level) begin
         rsp_row_ff <= row_ff - 16'd1;
         rsp_col_ff <= 12'(col_ff - ADDR_W'(1));
         rsp_level_ff <= cmd.emit_level ? level : '0;
         rsp_status_ff <= cmd.emit_flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_centre_row = rsp_row_ff;
   assign rsp_centre_column = rsp_col_ff;
   assign rsp_edge_level = $signed(rsp_level_ff);
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hdl/cnes_controller.sv
module cnes_controller
   import cnes_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cnes_status_type status,
   output cnes_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_WINDOW, S_SQ, S_ROOT, S_INSERT, S_ARG, S_NORM_LO, S_NORM_HI,
      S_DIV_INIT, S_DIV, S_SQ_MUL, S_SQ_FIX, S_MUL_LO, S_MUL_HI, S_EMIT
   } state_type;

   state_type state_ff;
   logic [2:0] nb_ff;
   logic [4:0] idx_ff;
   logic flag_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.nb = nb_ff;
      cmd.idx = idx_ff;
      unique case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_WINDOW: cmd.window = 1'b1;
         S_SQ: cmd.sq_step = 1'b1;
         S_ROOT: cmd.root_step = 1'b1;
         S_INSERT: cmd.insert = 1'b1;
         S_ARG: cmd.arg = 1'b1;
         S_NORM_LO: cmd.norm_lo = status.num_lt_den;
         S_NORM_HI: cmd.norm_hi = status.num_ge_2den;
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV: cmd.div_step = 1'b1;
         S_SQ_MUL: cmd.sq_mul = 1'b1;
         S_SQ_FIX: cmd.sq_fix = 1'b1;
         S_MUL_LO: cmd.mul_lo = 1'b1;
         S_MUL_HI: cmd.mul_hi = 1'b1;
         S_EMIT: begin
            cmd.emit_flag = !status.out_busy && flag_ff;
            cmd.emit_level = !status.out_busy && !flag_ff;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nb_ff <= '0;
         idx_ff <= '0;
         flag_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_WINDOW;
            S_WINDOW: begin
               nb_ff <= '0;
               idx_ff <= '0;
               state_ff <= status.interior ? S_SQ : S_IDLE;
            end
            S_SQ: begin
               if (idx_ff[1:0] == LAST_CHANNEL) begin
                  idx_ff <= ROOT_TOP_BIT;
                  state_ff <= S_ROOT;
               end else idx_ff <= idx_ff + 5'd1;
            end
            S_ROOT: begin
               if (idx_ff == '0) state_ff <= S_INSERT;
               else idx_ff <= idx_ff - 5'd1;
            end
            S_INSERT: begin
               idx_ff <= '0;
               if (nb_ff == LAST_NEIGHBOR) state_ff <= S_ARG;
               else begin
                  nb_ff <= nb_ff + 3'd1;
                  state_ff <= S_SQ;
               end
            end
            S_ARG: begin
               flag_ff <= status.nonpos;
               state_ff <= status.nonpos ? S_EMIT : S_NORM_LO;
            end
            S_NORM_LO: if (!status.num_lt_den) state_ff <= S_NORM_HI;
            S_NORM_HI: if (!status.num_ge_2den) state_ff <= S_DIV_INIT;
            S_DIV_INIT: begin
               idx_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (idx_ff == LAST_STEP) begin
                  idx_ff <= '0;
                  state_ff <= S_SQ_MUL;
               end else idx_ff <= idx_ff + 5'd1;
            end
            S_SQ_MUL: state_ff <= S_SQ_FIX;
            S_SQ_FIX: begin
               if (idx_ff == LAST_STEP) state_ff <= S_MUL_LO;
               else begin
                  idx_ff <= idx_ff + 5'd1;
                  state_ff <= S_SQ_MUL;
               end
            end
            S_MUL_LO: state_ff <= S_MUL_HI;
            S_MUL_HI: state_ff <= S_EMIT;
            S_EMIT: if (!status.out_busy) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/cnes_checker.sv
module cnes_checker
   import cnes_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_centre_row,
   input logic [11:0]        rsp_centre_column,
   input logic signed [14:0] rsp_edge_level,
   input logic               rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_level))
      else $error("result dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while busy");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_edge_level == 15'sd0)
      else $error("flagged result with nonzero level");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_centre_column != 12'd0 && rsp_centre_column != 12'd4095)
      else $error("result on border column");

endmodule

bind color_neighbor_edge_strength_unit cnes_checker u_cnes_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_centre_row(rsp_centre_row),
   .rsp_centre_column(rsp_centre_column), .rsp_edge_level(rsp_edge_level),
   .rsp_status(rsp_status)
);
